// ===== design/werm_pkg.sv =====
// ----------------------------------------------------------------------------
// werm_pkg - shared types and constants of the windowed event rate meter
// Field widths, register indexes, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package werm_pkg;

  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int COUNT_WIDTH_DEF   = 16;

  localparam int TIME_W      = 32;
  localparam int INTERVAL_W  = 16;
  localparam int WL_W        = 7;
  localparam int RATE_W      = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [WL_W-1:0]       WL_RESET       = WL_W'(8);
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_INTERVAL_MS   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_EVENT   = 1'b0,
    CMD_RESTART = 1'b1
  } command_t;

endpackage

// ===== design/werm_ifs.sv =====
// ----------------------------------------------------------------------------
// werm_ifs - handshake channels of the windowed event rate meter
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface werm_item_if;
  import werm_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, command, now_ms, input ready);
  modport sink   (input valid, command, now_ms, output ready);
endinterface

interface werm_result_if;
  import werm_pkg::*;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] average_rate;
  logic              window_closed;
  modport source (output valid, average_rate, window_closed, input ready);
  modport sink   (input valid, average_rate, window_closed, output ready);
endinterface

interface werm_cfg_if;
  import werm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/werm_ram.sv =====
// ----------------------------------------------------------------------------
// werm_ram - generic single-write, single-read synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module werm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/werm_div.sv =====
// ----------------------------------------------------------------------------
// werm_div - iterative restoring divider
// One quotient bit per cycle; done is high for a single cycle, registered together with the last bit.
// ----------------------------------------------------------------------------
module werm_div #(
  parameter int DIVD_W = 23,
  parameter int DIVS_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [DIVD_W-1:0] quo;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W:0]   rem_sub;
  logic              ge;

  always_comb begin
    rem_sh  = {rem, quo[DIVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    ge      = (rem_sh >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= CNT_W'(DIVD_W);
        busy <= 1'b1;
      end else if (busy) begin
        // shift in one quotient bit, restore when the trial subtract fails
        quo <= {quo[DIVD_W-2:0], ge};
        rem <= ge ? rem_sub[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("divider done without a finished run");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> (cnt != '0))
    else $error("divider busy with an exhausted count");

endmodule

// ===== design/windowed_event_rate_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_event_rate_meter - moving average of events per interval
// Counts events per interval, keeps closed interval counts in a history
// RAM and reports the rounded mean over the configured window.
//
//   channel  role    payload
//   item     sink    command, now_ms
//   result   source  average_rate, window_closed
//   cfg      sink    index, data (always ready)
//
// An event word passes from accept through S_CALC, S_START, the bit-serial
// divide of the window total in S_DIV, and S_DONE into the result register.
// A restart word sweeps the ring RAM to zero one entry per cycle, then
// replies. After reset the same sweep runs before the first word is accepted.
// A stalled result is held in the output register; the next word is taken
// meanwhile and waits finished until the register frees.
// ----------------------------------------------------------------------------
module windowed_event_rate_meter #(
  parameter int HISTORY_DEPTH = werm_pkg::HISTORY_DEPTH_DEF,
  parameter int COUNT_WIDTH   = werm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  werm_item_if.sink   item,
  werm_result_if.source result,
  werm_cfg_if.sink    cfg
);

  import werm_pkg::*;

  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int TOTAL_W = COUNT_WIDTH + SLOT_W;
  localparam int DIVD_W  = TOTAL_W + 1;
  localparam int QX_W    = DIVD_W + RATE_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_START,
    S_DIV,
    S_DONE
  } state_t;

  state_t                 state;
  logic                   clr_reply;
  logic [SLOT_W-1:0]      clr_addr;
  logic [WL_W-1:0]        window_length;
  logic [INTERVAL_W-1:0]  interval_ms;
  logic [TIME_W-1:0]      interval_start;
  logic [TIME_W-1:0]      next_deadline;
  logic [COUNT_WIDTH-1:0] current_count;
  logic [TOTAL_W-1:0]     window_total;
  logic [SLOT_W-1:0]      slot_index;
  logic [TIME_W-1:0]      now_q;
  logic                   closed_q;
  logic [RATE_W-1:0]      rate_q;

  logic                   accept;
  logic [WL_W-1:0]        eff_len;
  logic [TIME_W-1:0]      elapsed;
  logic                   close;
  logic [TIME_W-1:0]      twice_iv;
  logic [TIME_W-1:0]      deadline_next;
  logic [SLOT_W-1:0]      slot_next;
  logic [TOTAL_W-1:0]     total_next;
  logic [COUNT_WIDTH-1:0] count_inc;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  logic                   div_start;
  logic                   div_done;
  logic [DIVD_W-1:0]      div_dividend;
  logic [DIVD_W-1:0]      div_quotient;
  logic [QX_W-1:0]        quo_ext;

  assign accept     = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign cfg.ready  = 1'b1;

  always_comb begin
    if (window_length == '0) begin
      eff_len = WL_W'(1);
    end else if (TIME_W'(window_length) > TIME_W'(HISTORY_DEPTH)) begin
      eff_len = WL_W'(HISTORY_DEPTH);
    end else begin
      eff_len = window_length;
    end
  end

  always_comb begin
    elapsed  = now_q - interval_start;
    close    = (elapsed >= next_deadline);
    twice_iv = TIME_W'({interval_ms, 1'b0});
    // overrun shortens the next interval, floor at zero
    if (elapsed > twice_iv) begin
      deadline_next = '0;
    end else begin
      deadline_next = twice_iv - elapsed;
    end
    if (TIME_W'(slot_index) + TIME_W'(1) >= TIME_W'(eff_len)) begin
      slot_next = '0;
    end else begin
      slot_next = slot_index + SLOT_W'(1);
    end
    total_next = window_total - TOTAL_W'(ram_rdata) + TOTAL_W'(current_count);
    count_inc  = (current_count < COUNT_MAX) ? current_count + COUNT_WIDTH'(1)
                                             : current_count;
  end

  always_comb begin
    ram_we    = (state == S_CLEAR) || ((state == S_CALC) && close);
    ram_waddr = (state == S_CLEAR) ? clr_addr : slot_index;
    ram_wdata = (state == S_CLEAR) ? '0 : current_count;
  end

  werm_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (HISTORY_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (slot_index),
    .rdata (ram_rdata)
  );

  assign div_start    = (state == S_START);
  assign div_dividend = DIVD_W'(window_total) + DIVD_W'(eff_len >> 1);

  werm_div #(
    .DIVD_W (DIVD_W),
    .DIVS_W (WL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_len),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign quo_ext = QX_W'(div_quotient);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_reply      <= 1'b0;
      clr_addr       <= '0;
      window_length  <= WL_RESET;
      interval_ms    <= INTERVAL_RESET;
      interval_start <= '0;
      next_deadline  <= '0;
      current_count  <= '0;
      window_total   <= '0;
      slot_index     <= '0;
      result.valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg_reg_t'(cfg.index))
          REG_WINDOW_LENGTH: window_length <= cfg.data[WL_W-1:0];
          REG_INTERVAL_MS:   interval_ms   <= cfg.data[INTERVAL_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready && (state != S_DONE)) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_addr == SLOT_W'(HISTORY_DEPTH - 1)) begin
            clr_addr <= '0;
            state    <= clr_reply ? S_DONE : S_IDLE;
          end else begin
            clr_addr <= clr_addr + SLOT_W'(1);
          end
        end
        S_IDLE: begin
          if (accept) begin
            now_q <= item.now_ms;
            if (command_t'(item.command) == CMD_RESTART) begin
              interval_start <= item.now_ms;
              next_deadline  <= TIME_W'(interval_ms);
              current_count  <= '0;
              window_total   <= '0;
              closed_q       <= 1'b0;
              rate_q         <= '0;
              clr_reply      <= 1'b1;
              state          <= S_CLEAR;
            end else begin
              state <= S_CALC;
            end
          end
        end
        S_CALC: begin
          // ring entry at slot_index is on ram_rdata now
          if (close) begin
            window_total   <= total_next;
            current_count  <= COUNT_WIDTH'(1);
            slot_index     <= slot_next;
            interval_start <= now_q;
            next_deadline  <= deadline_next;
            closed_q       <= 1'b1;
          end else begin
            current_count <= count_inc;
            closed_q      <= 1'b0;
          end
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            rate_q <= (quo_ext > QX_W'(16'hFFFF)) ? '1 : quo_ext[RATE_W-1:0];
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!result.valid || result.ready) begin
            result.valid         <= 1'b1;
            result.average_rate  <= rate_q;
            result.window_closed <= closed_q;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ram_write_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_CALC) || (state == S_CLEAR)))
    else $error("ring written outside update or sweep");
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    accept |=> ((state == S_CALC) || (state == S_CLEAR)))
    else $error("accepted word not taken into processing");
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divide finished outside the wait state");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for the windowed event rate meter
// Feeds event and restart words with stepped millisecond timestamps, keeps an
// independent model of the interval counter and history ring, and compares
// every result word against it. Both channels idle in random bursts, and the
// result side once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;
  import werm_pkg::*;

  localparam int          RING_DEPTH = HISTORY_DEPTH_DEF;
  localparam int unsigned COUNT_MAX  = (1 << COUNT_WIDTH_DEF) - 1;

  typedef struct packed {
    command_t          command;
    logic [TIME_W-1:0] now_ms;
  } meter_word_t;

  typedef struct packed {
    logic [RATE_W-1:0] average_rate;
    logic              window_closed;
  } rate_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  werm_item_if   item ();
  werm_result_if result ();
  werm_cfg_if    cfg ();

  windowed_event_rate_meter i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

  always #5 clk = ~clk;

  // Model state of the meter
  logic [WL_W-1:0]       window_length_q = WL_RESET;
  logic [INTERVAL_W-1:0] interval_q      = INTERVAL_RESET;
  logic [TIME_W-1:0]     meter_start     = '0;
  logic [TIME_W-1:0]     meter_deadline  = '0;
  int unsigned           meter_count     = 0;
  longint                meter_total     = 0;
  logic [15:0]           meter_ring [RING_DEPTH];
  int unsigned           meter_slot      = 0;

  meter_word_t  pending_words  [$];
  rate_result_t expected_rates [$];
  rate_result_t want;

  int  mismatch_count   = 0;
  int  words_taken      = 0;
  int  send_gap         = 0;
  int  stall_left       = 0;
  int  hold_left        = 0;
  bit  pressure_done    = 1'b0;
  bit  calm             = 1'b0;
  bit  word_taken       = 1'b0;

  function automatic rate_result_t advance_meter(command_t cmd, logic [TIME_W-1:0] now);
    rate_result_t      r;
    logic [TIME_W-1:0] elapsed;
    int unsigned       slot;
    longint            nd;
    longint            span;
    longint            mean;
    r = '0;
    if (cmd == CMD_RESTART) begin
      meter_start    = now;
      meter_deadline = TIME_W'(interval_q);
      meter_count    = 0;
      meter_total    = 0;
      foreach (meter_ring[i]) meter_ring[i] = '0;
      return r;
    end
    span = (window_length_q == 0) ? 1 :
           (window_length_q > RING_DEPTH) ? RING_DEPTH : window_length_q;
    elapsed = now - meter_start;
    if (elapsed >= meter_deadline) begin
      slot = (meter_slot >= RING_DEPTH) ? 0 : meter_slot;
      meter_total = meter_total - longint'(meter_ring[slot]) + longint'(meter_count);
      meter_ring[slot] = 16'(meter_count);
      meter_count = 0;
      meter_slot  = (slot + 1 >= span) ? 0 : slot + 1;
      meter_start = now;
      nd = 2 * longint'(interval_q) - longint'(elapsed);
      meter_deadline = (nd < 0) ? '0 : nd[TIME_W-1:0];
      r.window_closed = 1'b1;
    end
    if (meter_count < COUNT_MAX) meter_count++;
    mean = (meter_total + span / 2) / span;
    r.average_rate = (mean > 65535) ? 16'hFFFF : mean[RATE_W-1:0];
    return r;
  endfunction

  // Sample both channels and the register port at the rising edge
  always @(posedge clk) begin
    word_taken = item.valid && item.ready;
    if (result.valid && result.ready) begin
      if (expected_rates.size() == 0) begin
        $error("result word with none expected: average_rate %0d window_closed %0d",
               result.average_rate, result.window_closed);
        mismatch_count++;
      end else begin
        want = expected_rates.pop_front();
        if (result.average_rate !== want.average_rate) begin
          $error("average_rate: expected %0d, got %0d", want.average_rate,
                 result.average_rate);
          mismatch_count++;
        end
        if (result.window_closed !== want.window_closed) begin
          $error("window_closed: expected %0d, got %0d", want.window_closed,
                 result.window_closed);
          mismatch_count++;
        end
      end
    end
    if (cfg.valid && cfg.ready) begin
      case (cfg_reg_t'(cfg.index))
        REG_WINDOW_LENGTH: window_length_q = cfg.data[WL_W-1:0];
        REG_INTERVAL_MS:   interval_q      = cfg.data[INTERVAL_W-1:0];
        default: ;
      endcase
    end
    if (word_taken) begin
      expected_rates.push_back(advance_meter(command_t'(item.command), item.now_ms));
      words_taken++;
    end
  end

  // Word driver: present the next pending word once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (!item.valid || word_taken) begin
      if (send_gap == 0 && !calm && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 14);
      if (send_gap > 0) begin
        send_gap--;
        item.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        item.valid   <= 1'b1;
        item.command <= pending_words[0].command;
        item.now_ms  <= pending_words[0].now_ms;
        void'(pending_words.pop_front());
      end else begin
        item.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off to back the block up
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (!pressure_done && words_taken >= 150) begin
        hold_left     = 400;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  task automatic push_word(command_t c, logic [TIME_W-1:0] t);
    meter_word_t w;
    w.command = c;
    w.now_ms  = t;
    pending_words.push_back(w);
  endtask

  // Hold until every word has been taken and every result has come back
  task automatic drain();
    while (pending_words.size() != 0 || item.valid || expected_rates.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    drain();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [TIME_W-1:0] clock_ms;
    int unsigned       iv;
    int unsigned       step;
    int unsigned       wl;
    foreach (meter_ring[i]) meter_ring[i] = '0;
    cfg.valid    = 1'b0;
    cfg.index    = '0;
    cfg.data     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Defaults: first event closes an empty interval, then deadline edges
    push_word(CMD_EVENT, 32'd0);
    push_word(CMD_EVENT, 32'd1999);
    push_word(CMD_EVENT, 32'd2000);
    push_word(CMD_EVENT, 32'd2001);
    push_word(CMD_EVENT, 32'd4500);
    push_word(CMD_EVENT, 32'h5555_5555);
    push_word(CMD_EVENT, 32'hAAAA_AAAA);
    // Restart just below the timestamp wrap, then events across it
    push_word(CMD_RESTART, 32'hFFFF_FF00);
    push_word(CMD_EVENT, 32'hFFFF_FFFF);
    push_word(CMD_EVENT, 32'h0000_0010);
    push_word(CMD_EVENT, 32'h0000_03F0);
    // Zero window length acts as one; zero interval closes on every event
    write_register(REG_WINDOW_LENGTH, 16'd0);
    write_register(REG_INTERVAL_MS, 16'd0);
    push_word(CMD_EVENT, 32'd5000);
    push_word(CMD_EVENT, 32'd5000);
    push_word(CMD_EVENT, 32'd5001);
    // Window length beyond the ring depth, longest interval
    write_register(REG_WINDOW_LENGTH, 16'd127);
    write_register(REG_INTERVAL_MS, 16'hFFFF);
    push_word(CMD_RESTART, 32'd0);
    push_word(CMD_EVENT, 32'd65534);
    push_word(CMD_EVENT, 32'd131070);
    // Advance the slot index well up, then shrink the window below it
    write_register(REG_WINDOW_LENGTH, 16'd64);
    write_register(REG_INTERVAL_MS, 16'd1);
    push_word(CMD_RESTART, 32'd100);
    for (int t = 102; t <= 107; t++) push_word(CMD_EVENT, t);
    write_register(REG_WINDOW_LENGTH, 16'd3);
    push_word(CMD_EVENT, 32'd108);
    push_word(CMD_EVENT, 32'd109);

    clock_ms = 32'd200;
    for (int phase = 0; phase < 11; phase++) begin
      case (phase % 4)
        0:       wl = 1;
        1:       wl = 64;
        default: wl = $urandom_range(0, 127);
      endcase
      case (phase % 3)
        0:       iv = 65535;
        1:       iv = $urandom_range(1, 200);
        default: iv = $urandom_range(0, 65535);
      endcase
      write_register(REG_WINDOW_LENGTH, {9'($urandom), WL_W'(wl)});
      write_register(REG_INTERVAL_MS, 16'(iv));
      if (phase == 10) calm = 1'b1;
      if ($urandom_range(0, 1) == 0) push_word(CMD_RESTART, clock_ms);
      for (int n = 0; n < 44; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: step = $urandom_range(0, iv / 6 + 1);
          6, 7:             step = iv + $urandom_range(0, 4) - 2;
          8:                step = $urandom_range(0, 3 * iv + 3);
          default:          step = $urandom_range(0, 2 * iv + 50);
        endcase
        clock_ms += step;
        if ($urandom_range(0, 32) == 0) clock_ms = $urandom();
        if ($urandom_range(0, 24) == 0) push_word(CMD_RESTART, clock_ms);
        else push_word(CMD_EVENT, clock_ms);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (expected_rates.size() != 0) begin
      $error("%0d result words never arrived", expected_rates.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
